// File: sv/ncq_pkg.sv
`default_nettype none
package ncq_pkg;

    localparam int MAX_ATOMS_DEF    = 1024;
    localparam int MAX_CONTACTS_DEF = 1024;
    localparam int SIG_SIZE_DEF     = 512;

    localparam logic [15:0] BETA_RESET = 16'd1280;

    // configuration register indexes
    localparam logic CFG_BETA = 1'b0;
    localparam logic CFG_NUM  = 1'b1;

    // request kinds
    localparam logic REQ_CONTACT = 1'b0;
    localparam logic REQ_COORD   = 1'b1;

    localparam int SIG_W   = 17;
    localparam int MUL_W   = 28;
    localparam int D2_W    = 51;
    localparam int Q_W     = 40;

    typedef struct packed {
        logic [9:0]         atom_a;
        logic [9:0]         atom_b;
        logic [15:0]        cutoff;
        logic signed [15:0] weight;
    } t_contact;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CRD,
        ST_ARD,
        ST_BRD,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_SQE,
        ST_SQRT,
        ST_ARG,
        ST_MAG,
        ST_KMUL,
        ST_LOOK,
        ST_WMUL,
        ST_ACC,
        ST_DONE
    } t_state;

    // sigmoid entry k in Q16 for a table of Size steps over 0..16
    function automatic logic [SIG_W-1:0] sig_entry(input int k, input int Size);
        longint one;
        longint t;
        longint eh;
        longint e;
        longint Dn;
        longint Den;
        longint n;
        longint r;
        one = longint'(1) << 30;
        t   = one;
        eh  = one;
        e   = one;
        n   = 1;
        while (t != 0) begin
            Dn = longint'(Size) * n;
            t  = (t * 16) / Dn;
            eh = (n % 2 == 1) ? eh - t : eh + t;
            n  = n + 1;
        end
        for (int i = 1; i <= k; i++) begin
            e = (e * eh + (one >> 1)) >>> 30;
        end
        Den = one + e;
        r   = (e * 65536 + Den / 2) / Den;
        return r[SIG_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/native_contact_q_sum_unit.sv
`default_nettype none
// native contact Q unit
// input channel (i_in_valid / o_in_ready) carries one request per handshake:
//   req_type 0 stores a contact pair (atoms, cutoff, weight) in the contact table,
//   req_type 1 stores one atom's coordinates; with last_atom set it also starts
//   the frame sum over contacts 0..num_contacts-1.
// configuration channel (i_cfg_valid / o_cfg_ready) writes beta (index 0) or
//   num_contacts (index 1); it is always ready. the user must ensure it is written
//   only while idle; the block itself does not enforce this. a frame sum runs, per
//   contact, three serial memory reads, six passes through the one shared 28x28
//   multiplier and a 26-step bit-serial square root.
// the input is not ready while a frame sum runs; the Q result sits in an output
//   register (o_out_valid / i_out_ready) and a new load may be taken while it
//   waits. a finished sum holds until the previous result has been taken.
// reset (synchronous, active low) returns the sequencer to idle, drops the
//   output, sets beta to 5.0 and num_contacts to 0. coordinate and contact
//   memories are not cleared and must be written before use.
module native_contact_q_sum_unit #(
    parameter int MAX_ATOMS    = ncq_pkg::MAX_ATOMS_DEF,
    parameter int MAX_CONTACTS = ncq_pkg::MAX_CONTACTS_DEF,
    parameter int SIG_SIZE     = ncq_pkg::SIG_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_req_type,
    input  wire logic [9:0]          i_slot,
    input  wire logic [9:0]          i_atom_a,
    input  wire logic [9:0]          i_atom_b,
    input  wire logic [15:0]         i_cutoff,
    input  wire logic signed [15:0]  i_weight,
    input  wire logic signed [23:0]  i_pos_x,
    input  wire logic signed [23:0]  i_pos_y,
    input  wire logic signed [23:0]  i_pos_z,
    input  wire logic                i_last_atom,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [39:0]       o_q_value,
    output logic                     o_saturated
);

    localparam int AAW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CAW   = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W = $clog2(MAX_CONTACTS + 1) + 1;
    localparam int KW    = $clog2(SIG_SIZE + 1);
    localparam int ACC_W = 34 + $clog2(MAX_CONTACTS + 1);
    localparam int CE_W  = $bits(ncq_pkg::t_contact);
    localparam int MW    = ncq_pkg::MUL_W;
    localparam int SW    = ncq_pkg::SIG_W;
    localparam int DW    = ncq_pkg::D2_W;

    // sigmoid table, built at elaboration
    logic [SW-1:0] sig_tab [SIG_SIZE+1];
    for (genvar g = 0; g <= SIG_SIZE; g++) begin : g_tab
        localparam logic [SW-1:0] SV = ncq_pkg::sig_entry(g, SIG_SIZE);
        assign sig_tab[g] = SV;
    end

    // configuration registers
    logic [15:0] r_beta;
    logic [10:0] r_num;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= ncq_pkg::BETA_RESET;
            r_num  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ncq_pkg::CFG_BETA: r_beta <= i_cfg_data;
                ncq_pkg::CFG_NUM:  r_num  <= i_cfg_data[10:0];
                default:           r_num  <= r_num;
            endcase
        end
    end

    // effective contact count
    logic [CNT_W-1:0] num_eff;
    always_comb begin
        if (32'(r_num) > 32'(MAX_CONTACTS)) begin
            num_eff = CNT_W'(MAX_CONTACTS);
        end else begin
            num_eff = CNT_W'(r_num);
        end
    end

    ncq_pkg::t_state r_state, n_state;
    logic in_acc;
    assign o_in_ready = (r_state == ncq_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // datapath registers
    logic [CNT_W-1:0]       r_cnt;
    ncq_pkg::t_contact      r_ent;
    logic signed [23:0]     r_ax, r_ay, r_az;
    logic                   r_b_ok;
    logic signed [24:0]     r_dx, r_dy, r_dz;
    logic signed [2*MW-1:0] r_prod;
    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_root;
    logic [DW-1:0]          r_bit;
    logic                   r_neg;
    logic [20:0]            r_mag;
    logic [SW-1:0]          r_sig;
    logic signed [ACC_W-1:0] r_acc;
    logic                   r_out_valid;
    logic signed [39:0]     r_q;
    logic                   r_sat;

    // memories
    logic [31:0]        slot32, slot_cnt;
    logic               atom_we, cont_we;
    logic [AAW-1:0]     atom_raddr;
    logic [CAW-1:0]     cont_raddr;
    logic [23:0]        rx, ry, rz;
    logic [CE_W-1:0]    cont_rdata;
    ncq_pkg::t_contact  cont_wdata, cont_ent;
    logic [31:0]        a32, b32;

    assign slot32  = 32'(i_slot);
    assign atom_we = in_acc && (i_req_type == ncq_pkg::REQ_COORD)
                     && (slot32 < 32'(MAX_ATOMS));
    assign cont_we = in_acc && (i_req_type == ncq_pkg::REQ_CONTACT)
                     && (slot32 < 32'(MAX_CONTACTS));
    assign cont_wdata = '{atom_a: i_atom_a, atom_b: i_atom_b,
                          cutoff: i_cutoff, weight: i_weight};
    assign cont_ent = ncq_pkg::t_contact'(cont_rdata);
    assign slot_cnt = 32'(r_cnt);
    assign cont_raddr = slot_cnt[CAW-1:0];
    assign a32 = 32'(cont_ent.atom_a);
    assign b32 = 32'(r_ent.atom_b);
    assign atom_raddr = (r_state == ncq_pkg::ST_ARD) ? a32[AAW-1:0] : b32[AAW-1:0];

    ncq_ram #(.WIDTH(24), .DEPTH(MAX_ATOMS)) u_xram (
        .i_clk(i_clk), .i_we(atom_we), .i_waddr(slot32[AAW-1:0]), .i_wdata(i_pos_x),
        .i_raddr(atom_raddr), .o_rdata(rx));
    ncq_ram #(.WIDTH(24), .DEPTH(MAX_ATOMS)) u_yram (
        .i_clk(i_clk), .i_we(atom_we), .i_waddr(slot32[AAW-1:0]), .i_wdata(i_pos_y),
        .i_raddr(atom_raddr), .o_rdata(ry));
    ncq_ram #(.WIDTH(24), .DEPTH(MAX_ATOMS)) u_zram (
        .i_clk(i_clk), .i_we(atom_we), .i_waddr(slot32[AAW-1:0]), .i_wdata(i_pos_z),
        .i_raddr(atom_raddr), .o_rdata(rz));
    ncq_ram #(.WIDTH(CE_W), .DEPTH(MAX_CONTACTS)) u_cram (
        .i_clk(i_clk), .i_we(cont_we), .i_waddr(slot32[CAW-1:0]), .i_wdata(cont_wdata),
        .i_raddr(cont_raddr), .o_rdata(cont_rdata));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ncq_pkg::ST_IDLE: begin
                if (in_acc && (i_req_type == ncq_pkg::REQ_COORD) && i_last_atom) begin
                    n_state = (num_eff == '0) ? ncq_pkg::ST_DONE : ncq_pkg::ST_CRD;
                end
            end
            ncq_pkg::ST_CRD:  n_state = ncq_pkg::ST_ARD;
            ncq_pkg::ST_ARD:  n_state = ncq_pkg::ST_BRD;
            ncq_pkg::ST_BRD:  n_state = ncq_pkg::ST_DIFF;
            ncq_pkg::ST_DIFF: n_state = ncq_pkg::ST_SQX;
            ncq_pkg::ST_SQX:  n_state = ncq_pkg::ST_SQY;
            ncq_pkg::ST_SQY:  n_state = ncq_pkg::ST_SQZ;
            ncq_pkg::ST_SQZ:  n_state = ncq_pkg::ST_SQE;
            ncq_pkg::ST_SQE:  n_state = ncq_pkg::ST_SQRT;
            ncq_pkg::ST_SQRT: begin
                if (r_bit[1:0] != 2'b00 || r_bit == '0) begin
                    n_state = ncq_pkg::ST_ARG;
                end
            end
            ncq_pkg::ST_ARG:  n_state = ncq_pkg::ST_MAG;
            ncq_pkg::ST_MAG:  n_state = ncq_pkg::ST_KMUL;
            ncq_pkg::ST_KMUL: n_state = ncq_pkg::ST_LOOK;
            ncq_pkg::ST_LOOK: n_state = ncq_pkg::ST_WMUL;
            ncq_pkg::ST_WMUL: n_state = ncq_pkg::ST_ACC;
            ncq_pkg::ST_ACC: begin
                n_state = (r_cnt + 1'b1 == num_eff) ? ncq_pkg::ST_DONE : ncq_pkg::ST_CRD;
            end
            ncq_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ncq_pkg::ST_IDLE;
                end
            end
            default: n_state = ncq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier operand select
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic [SW-1:0]          s_val;
    logic signed [MW-1:0]   diff;
    assign s_val = r_neg ? SW'(17'd65536 - r_sig) : r_sig;
    assign diff  = MW'($signed({1'b0, r_root[25:0]})) - MW'($signed({1'b0, r_ent.cutoff}));
    always_comb begin
        case (r_state)
            ncq_pkg::ST_SQX: begin mul_a = MW'(r_dx); mul_b = MW'(r_dx); end
            ncq_pkg::ST_SQY: begin mul_a = MW'(r_dy); mul_b = MW'(r_dy); end
            ncq_pkg::ST_SQZ: begin mul_a = MW'(r_dz); mul_b = MW'(r_dz); end
            ncq_pkg::ST_ARG: begin mul_a = diff; mul_b = MW'($signed({1'b0, r_beta})); end
            ncq_pkg::ST_KMUL: begin
                mul_a = MW'($signed({1'b0, r_mag}));
                mul_b = MW'(SIG_SIZE);
            end
            ncq_pkg::ST_WMUL: begin
                mul_a = MW'(r_ent.weight);
                mul_b = MW'($signed({1'b0, s_val}));
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // magnitude, table index and output rounding
    logic signed [2*MW-1:0] arg_abs;
    logic [33:0]            k_sum;
    logic [13:0]            k_full;
    logic [31:0]            k_idx;
    logic [DW-1:0]          trial;
    logic signed [63:0]     q_full;
    assign arg_abs = r_prod[2*MW-1] ? -r_prod : r_prod;
    assign k_sum   = r_prod[33:0] + 34'(1 << 19);
    assign k_full  = k_sum[33:20];
    assign k_idx   = (32'(k_full) > 32'(SIG_SIZE)) ? 32'(SIG_SIZE) : 32'(k_full);
    assign trial   = r_root + r_bit;
    assign q_full  = (64'(r_acc) + 64'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ncq_pkg::ST_IDLE: begin
                r_cnt <= '0;
                r_acc <= '0;
            end
            ncq_pkg::ST_ARD: begin
                r_ent <= cont_ent;
            end
            ncq_pkg::ST_BRD: begin
                // coordinates of an atom beyond the store read as zero
                if (32'(r_ent.atom_a) < 32'(MAX_ATOMS)) begin
                    r_ax <= rx; r_ay <= ry; r_az <= rz;
                end else begin
                    r_ax <= '0; r_ay <= '0; r_az <= '0;
                end
                r_b_ok <= (b32 < 32'(MAX_ATOMS));
            end
            ncq_pkg::ST_DIFF: begin
                r_dx <= 25'(r_ax) - (r_b_ok ? 25'($signed(rx)) : 25'sd0);
                r_dy <= 25'(r_ay) - (r_b_ok ? 25'($signed(ry)) : 25'sd0);
                r_dz <= 25'(r_az) - (r_b_ok ? 25'($signed(rz)) : 25'sd0);
            end
            ncq_pkg::ST_SQX: begin
                r_prod <= mul_p;
                r_rem  <= '0;
            end
            ncq_pkg::ST_SQY, ncq_pkg::ST_SQZ: begin
                r_prod <= mul_p;
                r_rem  <= r_rem + r_prod[DW-1:0];
            end
            ncq_pkg::ST_SQE: begin
                r_rem  <= r_rem + r_prod[DW-1:0];
                r_root <= '0;
                r_bit  <= DW'(1) << (DW - 1);
            end
            ncq_pkg::ST_SQRT: begin
                // one result bit per cycle
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ncq_pkg::ST_ARG, ncq_pkg::ST_KMUL, ncq_pkg::ST_WMUL: begin
                r_prod <= mul_p;
            end
            ncq_pkg::ST_MAG: begin
                r_neg <= r_prod[2*MW-1];
                r_mag <= (arg_abs > (2*MW)'(1 << 20)) ? 21'(1 << 20) : arg_abs[20:0];
            end
            ncq_pkg::ST_LOOK: begin
                r_sig <= sig_tab[k_idx[KW-1:0]];
            end
            ncq_pkg::ST_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ncq_pkg::ST_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
            if (q_full > 64'sd549755813887) begin
                r_q   <= 40'sh7F_FFFF_FFFF;
                r_sat <= 1'b1;
            end else if (q_full < -64'sd549755813888) begin
                r_q   <= 40'sh80_0000_0000;
                r_sat <= 1'b1;
            end else begin
                r_q   <= q_full[39:0];
                r_sat <= 1'b0;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_q_value   = r_q;
    assign o_saturated = r_sat;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ncq_pkg::ST_IDLE && r_state != ncq_pkg::ST_DONE) |-> r_cnt < num_eff)
        else $error("contact counter out of range");
    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ncq_pkg::ST_SQRT |-> $onehot0(r_bit))
        else $error("square root bit not one-hot");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ncq_pkg::ST_DONE && (!r_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("finished sum not presented");
    a_sat_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_q_value == 40'sh7F_FFFF_FFFF || o_q_value == 40'sh80_0000_0000))
        else $error("saturated flag without clamped value");

endmodule
`default_nettype wire

// File: sv/ncq_ram.sv
`default_nettype none
module ncq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: dv/native_contact_q_sum_unit_tb.sv
`timescale 1ns / 1ps
module native_contact_q_sum_unit_tb;

    localparam int N_ATOMS    = 1024;
    localparam int N_CONTACTS = 1024;
    localparam int BIG_CONTACTS = 128;
    localparam int SIG_STEPS  = 512;
    localparam int STALL_LIMIT = 200000;
    localparam int POOL_N     = 16;

    typedef struct {
        logic               req_type;
        logic [9:0]         slot;
        logic [9:0]         atom_a;
        logic [9:0]         atom_b;
        logic [15:0]        cutoff;
        logic signed [15:0] weight;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic               last_atom;
    } t_load_req;

    typedef struct {
        logic               q_sat;
        logic signed [39:0] q_val;
    } t_q_result;

    // one directed row: either a register write or a request with optional typed result
    typedef struct {
        bit                 is_reg;
        logic               reg_idx;
        logic [15:0]        reg_data;
        t_load_req          req;
        bit                 typed;
        t_q_result          typed_q;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_req_type;
    logic [9:0]         i_slot;
    logic [9:0]         i_atom_a;
    logic [9:0]         i_atom_b;
    logic [15:0]        i_cutoff;
    logic signed [15:0] i_weight;
    logic signed [23:0] i_pos_x;
    logic signed [23:0] i_pos_y;
    logic signed [23:0] i_pos_z;
    logic               i_last_atom;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [39:0] o_q_value;
    logic               o_saturated;

    native_contact_q_sum_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_slot(i_slot),
        .i_atom_a(i_atom_a), .i_atom_b(i_atom_b),
        .i_cutoff(i_cutoff), .i_weight(i_weight),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_last_atom(i_last_atom),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_q_value(o_q_value), .o_saturated(o_saturated)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow state of the unit
    logic signed [23:0] x_mem [N_ATOMS];
    logic signed [23:0] y_mem [N_ATOMS];
    logic signed [23:0] z_mem [N_ATOMS];
    ncq_pkg::t_contact  pair_mem [N_CONTACTS];
    bit                 atom_loaded [N_ATOMS];
    bit                 pair_loaded [N_CONTACTS];
    logic [15:0]        beta_reg;
    logic [10:0]        pair_count;
    longint             sigmoid_q16 [SIG_STEPS + 1];

    t_q_result          q_pending [$];
    int                 errors = 0;
    int                 frames_checked = 0;
    int                 reqs_sent = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 quiet_cycles = 0;
    logic [9:0]         atom_pool [POOL_N];

    // sigmoid table in q16, exp(-16k/S) stepped in q30
    function automatic void build_sigmoid();
        longint one;
        longint term;
        longint eh;
        longint e;
        longint n;
        longint den;
        one  = longint'(1) << 30;
        term = one;
        eh   = one;
        e    = one;
        n    = 1;
        while (term != 0) begin
            term = (term * 16) / (longint'(SIG_STEPS) * n);
            eh   = (n % 2 == 1) ? eh - term : eh + term;
            n++;
        end
        for (int k = 0; k <= SIG_STEPS; k++) begin
            if (k > 0) e = (e * eh + (one >>> 1)) >>> 30;
            den = one + e;
            sigmoid_q16[k] = (e * 65536 + den / 2) / den;
        end
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // weighted sigmoid sum over the active contacts, rounded and clamped to signed 40 bits
    function automatic t_q_result contact_q_sum();
        t_q_result res;
        int        n;
        longint    acc;
        longint    dx, dy, dz, d, arg, mag, k, s, r;
        ncq_pkg::t_contact p;
        n   = (pair_count > N_CONTACTS) ? N_CONTACTS : int'(pair_count);
        acc = 0;
        for (int c = 0; c < n; c++) begin
            p   = pair_mem[c];
            dx  = longint'(x_mem[p.atom_a]) - longint'(x_mem[p.atom_b]);
            dy  = longint'(y_mem[p.atom_a]) - longint'(y_mem[p.atom_b]);
            dz  = longint'(z_mem[p.atom_a]) - longint'(z_mem[p.atom_b]);
            d   = longint'(int_sqrt(dx * dx + dy * dy + dz * dz));
            arg = longint'(beta_reg) * (d - longint'(p.cutoff));
            mag = (arg < 0) ? -arg : arg;
            if (mag > (longint'(16) << 16)) mag = longint'(16) << 16;
            k = (mag * SIG_STEPS + (longint'(1) << 19)) >>> 20;
            if (k > SIG_STEPS) k = SIG_STEPS;
            s = sigmoid_q16[k];
            if (arg < 0) s = 65536 - s;
            acc += longint'(p.weight) * s;
        end
        r = (acc + (longint'(1) << 15)) >>> 16;
        res.q_sat = 1'b0;
        if (r > (longint'(1) << 39) - 1) begin
            r = (longint'(1) << 39) - 1;
            res.q_sat = 1'b1;
        end
        if (r < -(longint'(1) << 39)) begin
            r = -(longint'(1) << 39);
            res.q_sat = 1'b1;
        end
        res.q_val = r[39:0];
        return res;
    endfunction

    // a frame may only read contacts and atoms that were loaded
    function automatic bit frame_is_loaded(input t_load_req r);
        int n;
        n = (pair_count > N_CONTACTS) ? N_CONTACTS : int'(pair_count);
        for (int c = 0; c < n; c++) begin
            if (!pair_loaded[c]) return 0;
            if (!atom_loaded[pair_mem[c].atom_a] && pair_mem[c].atom_a != r.slot) return 0;
            if (!atom_loaded[pair_mem[c].atom_b] && pair_mem[c].atom_b != r.slot) return 0;
        end
        return 1;
    endfunction

    // update shadow state for an accepted request and queue its Q value
    function automatic void absorb_request(input t_load_req r, input bit typed,
                                           input t_q_result typed_q);
        ncq_pkg::t_contact p;
        if (r.req_type == ncq_pkg::REQ_CONTACT) begin
            p.atom_a = r.atom_a;
            p.atom_b = r.atom_b;
            p.cutoff = r.cutoff;
            p.weight = r.weight;
            pair_mem[r.slot]    = p;
            pair_loaded[r.slot] = 1;
            return;
        end
        x_mem[r.slot] = r.pos_x;
        y_mem[r.slot] = r.pos_y;
        z_mem[r.slot] = r.pos_z;
        atom_loaded[r.slot] = 1;
        if (r.last_atom) q_pending.push_back(typed ? typed_q : contact_q_sum());
    endfunction

    task automatic send_request(input t_load_req r, input bit typed, input t_q_result typed_q);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= r.req_type;
        i_slot      <= r.slot;
        i_atom_a    <= r.atom_a;
        i_atom_b    <= r.atom_b;
        i_cutoff    <= r.cutoff;
        i_weight    <= r.weight;
        i_pos_x     <= r.pos_x;
        i_pos_y     <= r.pos_y;
        i_pos_z     <= r.pos_z;
        i_last_atom <= r.last_atom;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_request(r, typed, typed_q);
        reqs_sent++;
    endtask

    // drop valid and let the unit drain before touching registers
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (q_pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ncq_pkg::CFG_BETA) beta_reg = data;
        else pair_count = data[10:0];
    endtask

    function automatic t_load_req coord_req(input logic [9:0] atom, input logic signed [23:0] x,
                                            input logic signed [23:0] y,
                                            input logic signed [23:0] z, input logic last);
        t_load_req r;
        r = '{default: '0};
        r.req_type  = ncq_pkg::REQ_COORD;
        r.slot      = atom;
        r.pos_x     = x;
        r.pos_y     = y;
        r.pos_z     = z;
        r.last_atom = last;
        return r;
    endfunction

    function automatic t_load_req pair_req(input logic [9:0] slot, input logic [9:0] a,
                                           input logic [9:0] b, input logic [15:0] cutoff,
                                           input logic signed [15:0] weight);
        t_load_req r;
        r = '{default: '0};
        r.req_type = ncq_pkg::REQ_CONTACT;
        r.slot     = slot;
        r.atom_a   = a;
        r.atom_b   = b;
        r.cutoff   = cutoff;
        r.weight   = weight;
        return r;
    endfunction

    function automatic t_stim_row req_row(input t_load_req r, input bit typed,
                                          input logic signed [39:0] q);
        t_stim_row row;
        row = '{default: '0};
        row.req           = r;
        row.typed         = typed;
        row.typed_q.q_val = q;
        row.typed_q.q_sat = 1'b0;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic idx, input logic [15:0] data);
        t_stim_row row;
        row = '{default: '0};
        row.is_reg   = 1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(99) < 85) return 24'(int'($urandom_range(4095)) - 2048);
        return 24'($urandom);
    endfunction

    // one random request: mostly well-formed loads over the pool, some noise
    function automatic t_load_req random_request();
        t_load_req r;
        int        roll;
        roll = $urandom_range(99);
        if (roll < 25 && pair_count != 0) begin
            r = pair_req(10'($urandom_range(int'(pair_count) - 1)),
                         atom_pool[$urandom_range(POOL_N - 1)],
                         atom_pool[$urandom_range(POOL_N - 1)],
                         ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4095)),
                         16'($urandom));
        end else if (roll < 75) begin
            r = coord_req(atom_pool[$urandom_range(POOL_N - 1)], rand_coord(), rand_coord(),
                          rand_coord(), $urandom_range(99) < 25);
        end else if (roll < 88) begin
            r = pair_req(10'($urandom), 10'($urandom), 10'($urandom), 16'($urandom),
                         16'($urandom));
            r.last_atom = 1'($urandom);
        end else begin
            r = coord_req(10'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          1'($urandom));
        end
        if (r.req_type == ncq_pkg::REQ_COORD && r.last_atom && !frame_is_loaded(r)) begin
            r.last_atom = 1'b0;
        end
        return r;
    endfunction

    // load every active contact and every pool atom so frames can run at once
    task automatic prime_frame_data();
        t_q_result none;
        none = '{default: '0};
        for (int c = 0; c < int'(pair_count); c++)
            send_request(pair_req(10'(c), atom_pool[$urandom_range(POOL_N - 1)],
                                  atom_pool[$urandom_range(POOL_N - 1)],
                                  16'($urandom_range(4095)), 16'($urandom)), 0, none);
        for (int i = 0; i < POOL_N; i++)
            send_request(coord_req(atom_pool[i], rand_coord(), rand_coord(), rand_coord(),
                                   1'b0), 0, none);
    endtask

    // receiver: random stalls, compare each accepted Q value with the oldest expectation
    always @(posedge i_clk) begin
        t_q_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (q_pending.size() == 0) begin
                $display("%0t: unexpected Q value %0d sat %0d", $time, o_q_value,
                         o_saturated);
                errors++;
            end else begin
                want = q_pending.pop_front();
                frames_checked++;
                if (o_q_value !== want.q_val) begin
                    $display("%0t: q_value expected %0d actual %0d", $time, want.q_val,
                             o_q_value);
                    errors++;
                end
                if (o_saturated !== want.q_sat) begin
                    $display("%0t: saturated expected %0d actual %0d", $time, want.q_sat,
                             o_saturated);
                    errors++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("native_contact_q_sum_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row   dir_tab [$];
        t_q_result   none;
        logic [15:0] beta_set [4];
        int          pairs_set [3];
        int          budget;

        none = '{default: '0};
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= ncq_pkg::CFG_BETA;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_req_type  <= ncq_pkg::REQ_CONTACT;
        i_slot      <= '0;
        i_atom_a    <= '0;
        i_atom_b    <= '0;
        i_cutoff    <= '0;
        i_weight    <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pos_z     <= '0;
        i_last_atom <= 1'b0;
        i_out_ready <= 1'b1;
        beta_reg    = ncq_pkg::BETA_RESET;
        pair_count  = '0;
        build_sigmoid();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: empty walk, sigmoid midpoint and clamp, field extremes
        dir_tab.push_back(req_row(coord_req(10'd5, '0, '0, '0, 1'b1), 1, 40'sd0));
        dir_tab.push_back(reg_row(ncq_pkg::CFG_NUM, 16'd1));
        dir_tab.push_back(req_row(pair_req(10'd0, 10'd0, 10'd1023, 16'd0, -16'sd32768), 0, 0));
        dir_tab.push_back(req_row(coord_req(10'd0, '0, '0, '0, 1'b0), 0, 0));
        dir_tab.push_back(req_row(coord_req(10'd1023, '0, '0, '0, 1'b1), 1, -40'sd16384));
        dir_tab.push_back(req_row(pair_req(10'd0, 10'd0, 10'd1023, 16'hFFFF, 16'sd32767), 0, 0));
        dir_tab.push_back(req_row(coord_req(10'd1023, '0, '0, '0, 1'b1), 1, 40'sd32767));
        dir_tab.push_back(req_row(pair_req(10'd1023, 10'd1023, 10'd0, 16'h8000, 16'sd1), 0, 0));
        dir_tab[$].req.last_atom = 1'b1;
        dir_tab.push_back(req_row(coord_req(10'd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                                            1'b0), 0, 0));
        dir_tab.push_back(req_row(coord_req(10'd1023, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                                            1'b1), 0, 0));
        dir_tab.push_back(reg_row(ncq_pkg::CFG_BETA, 16'd0));
        dir_tab.push_back(req_row(coord_req(10'd1023, 24'sd256, 24'sd0, 24'sd0, 1'b1), 0, 0));
        dir_tab.push_back(reg_row(ncq_pkg::CFG_BETA, 16'hFFFF));
        dir_tab.push_back(req_row(pair_req(10'd0, 10'd0, 10'd1023, 16'd300, 16'sd4096), 0, 0));
        dir_tab.push_back(req_row(coord_req(10'd1023, 24'sd256, 24'sd0, 24'sd0, 1'b1), 0, 0));
        dir_tab.push_back(reg_row(ncq_pkg::CFG_BETA, ncq_pkg::BETA_RESET));
        dir_tab.push_back(req_row(coord_req(10'd1023, 24'sd0, 24'sd300, 24'sd0, 1'b1), 0, 0));
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_reg) write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
            else send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].typed_q);
        end

        // random phases under three idle patterns
        beta_set  = '{16'hFFFF, 16'd0, 16'($urandom), ncq_pkg::BETA_RESET};
        pairs_set = '{3, 6, 12};
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 31 : (ph == 1) ? 53 : 0;
            recv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 31 : 0;
            atom_pool[0] = 10'd0;
            atom_pool[1] = 10'd1023;
            for (int i = 2; i < POOL_N; i++) atom_pool[i] = 10'($urandom);
            write_reg(ncq_pkg::CFG_BETA, beta_set[ph]);
            write_reg(ncq_pkg::CFG_NUM, 16'(pairs_set[ph]));
            prime_frame_data();
            budget = 130 - pairs_set[ph] - POOL_N;
            for (int n = 0; n < budget; n++) send_request(random_request(), 0, none);
        end

        // one long walk over a larger contact table
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(ncq_pkg::CFG_BETA, beta_set[3]);
        write_reg(ncq_pkg::CFG_NUM, 16'(BIG_CONTACTS));
        prime_frame_data();
        send_request(coord_req(atom_pool[0], rand_coord(), rand_coord(), rand_coord(), 1'b1),
                     0, none);

        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests and %0d frame sums", reqs_sent, frames_checked);
        $display("beta at 0, 5.0, max and random; contact counts 0, 1, small and 128");
        if (errors == 0 && q_pending.size() == 0) begin
            $display("native_contact_q_sum_unit verification clean");
        end else begin
            $display("native_contact_q_sum_unit verification failed");
        end
        $finish;
    end

endmodule
